>>> hdl/lpsm_pkg.sv
`default_nettype none
package lpsm_pkg;

    // table sizes
    localparam int NUM_SLOTS_C  = 16;
    localparam int NUM_BLOCKS_C = 1024;

    // field widths
    localparam int SLOT_W = 4;
    localparam int RANK_W = 4;
    localparam int BLK_W  = 10;

    // request modes
    localparam logic MODE_ACCESS     = 1'b0;
    localparam logic MODE_INVALIDATE = 1'b1;

    typedef struct packed {
        logic             mode;
        logic [BLK_W-1:0] block_number;
        logic             is_write;
    } req_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              evicted_valid;
        logic [BLK_W-1:0]  evicted_block;
        logic              log_change;
    } rsp_t;

    // map memory port bundle
    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [BLK_W-1:0]  rd_addr;
        logic [BLK_W-1:0]  wr_addr;
        logic [SLOT_W-1:0] wr_data;
    } map_ctl_t;

endpackage
`default_nettype wire

>>> hdl/lpsm_req_if.sv
`default_nettype none
interface lpsm_req_if import lpsm_pkg::*; ();
    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/lpsm_rsp_if.sv
`default_nettype none
interface lpsm_rsp_if import lpsm_pkg::*; ();
    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/lru_page_slot_manager_unit.sv
`default_nettype none
// Fully associative LRU page-slot table with 16 slots for disk blocks. A request
// either accesses a block (hit promotes its slot; a miss takes the lowest free
// slot or evicts the least recently used one and reports the evicted block) or
// invalidates a block and frees its slot. A request passes through the idle,
// lookup and execute states. The accepting cycle launches the block map memory
// read. The lookup state checks residency and chooses the slot. The execute state
// updates ranks and writes back, and the response is registered at its end.
// Requests are handled one at a time. A new request is accepted
// while the previous response still waits in the output register. Its write-back
// cycle then stalls until that response is taken. No clearing pass is needed
// after reset: residency is confirmed against the slot table.
module lru_page_slot_manager_unit import lpsm_pkg::*; #(
    parameter int NUM_BLOCKS = NUM_BLOCKS_C
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    lpsm_req_if.sink   req,
    lpsm_rsp_if.source rsp
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOOK = 2'd1;
    localparam logic [1:0] ST_EXEC = 2'd2;

    localparam logic [RANK_W:0]   RANK_NEW = (RANK_W + 1)'(NUM_SLOTS_C);
    localparam logic [RANK_W-1:0] RANK_LRU = RANK_W'(NUM_SLOTS_C - 1);

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    req_t              item_reg;
    logic              inr_reg;
    logic              hit_reg;
    logic              evict_reg;
    logic [SLOT_W-1:0] tgt_reg;
    logic              rsp_valid_reg;
    rsp_t              rsp_data_reg;

    logic              slot_valid_reg [NUM_SLOTS_C];
    logic [BLK_W-1:0]  slot_block_reg [NUM_SLOTS_C];
    logic [RANK_W-1:0] slot_rank_reg  [NUM_SLOTS_C];

    map_ctl_t          map_ctl;
    logic [SLOT_W-1:0] map_q;
    logic              accept;
    logic              in_range;
    logic [SLOT_W-1:0] stb_sel;
    logic [BLK_W-1:0]  stb_rd;
    logic              look_hit;
    logic              free_any;
    logic [SLOT_W-1:0] free_idx;
    logic [SLOT_W-1:0] lru_idx;
    logic              exec_go;
    logic [RANK_W:0]   old_rank;
    rsp_t              rsp_next;

    assign accept   = req.valid && req.ready;
    assign in_range = 32'(req.data.block_number) < NUM_BLOCKS;
    assign req.ready = (state_reg == ST_IDLE);
    assign exec_go  = (state_reg == ST_EXEC) && (!rsp_valid_reg || rsp.ready);

    // block map memory
    always_comb
    begin
        map_ctl.rd_en   = accept && in_range;
        map_ctl.rd_addr = req.data.block_number;
        map_ctl.wr_en   = exec_go && inr_reg && (item_reg.mode == MODE_ACCESS) && !hit_reg;
        map_ctl.wr_addr = item_reg.block_number;
        map_ctl.wr_data = tgt_reg;
    end

    lpsm_block_map #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_map (
        .clk     (clk),
        .ctl     (map_ctl),
        .rd_data (map_q)
    );

    // single slot-to-block read port
    assign stb_sel = (state_reg == ST_LOOK) ? map_q : tgt_reg;
    assign stb_rd  = slot_block_reg[stb_sel];

    // residency check and slot choice
    always_comb
    begin
        look_hit = inr_reg && slot_valid_reg[map_q] && (stb_rd == item_reg.block_number);
        free_any = 1'b0;
        free_idx = '0;
        lru_idx  = '0;
        for (int i = NUM_SLOTS_C - 1; i >= 0; i--)
        begin
            if (!slot_valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = SLOT_W'(i);
            end
            if (slot_rank_reg[i] == RANK_LRU)
            begin
                lru_idx = SLOT_W'(i);
            end
        end
    end

    // old rank of the slot being promoted
    assign old_rank = (hit_reg || evict_reg) ? {1'b0, slot_rank_reg[tgt_reg]} : RANK_NEW;

    // response
    always_comb
    begin
        rsp_next = '0;
        if (inr_reg)
        begin
            if (item_reg.mode == MODE_INVALIDATE)
            begin
                rsp_next.hit  = hit_reg;
                rsp_next.slot = hit_reg ? tgt_reg : '0;
            end
            else
            begin
                rsp_next.hit           = hit_reg;
                rsp_next.slot          = tgt_reg;
                rsp_next.evicted_valid = evict_reg;
                rsp_next.evicted_block = evict_reg ? stb_rd : '0;
                rsp_next.log_change    = item_reg.is_write;
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_LOOK;
            ST_LOOK: state_next = ST_EXEC;
            ST_EXEC: if (exec_go) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (exec_go)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // request and decision payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= req.data;
            inr_reg  <= in_range;
        end
        if (state_reg == ST_LOOK)
        begin
            hit_reg   <= look_hit;
            evict_reg <= !look_hit && !free_any && (item_reg.mode == MODE_ACCESS);
            tgt_reg   <= look_hit ? map_q : (free_any ? free_idx : lru_idx);
        end
        if (exec_go)
        begin
            rsp_data_reg <= rsp_next;
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    // slot table: valid and recency rank
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS_C; i++)
            begin
                slot_valid_reg[i] <= 1'b0;
                slot_rank_reg[i]  <= '0;
            end
        end
        else if (exec_go && inr_reg)
        begin
            if (item_reg.mode == MODE_INVALIDATE)
            begin
                if (hit_reg)
                begin
                    for (int i = 0; i < NUM_SLOTS_C; i++)
                    begin
                        if ((SLOT_W'(i) != tgt_reg) && slot_valid_reg[i]
                            && (slot_rank_reg[i] > slot_rank_reg[tgt_reg]))
                        begin
                            slot_rank_reg[i] <= slot_rank_reg[i] - 1'b1;
                        end
                    end
                    slot_valid_reg[tgt_reg] <= 1'b0;
                    slot_rank_reg[tgt_reg]  <= '0;
                end
            end
            else
            begin
                for (int i = 0; i < NUM_SLOTS_C; i++)
                begin
                    if ((SLOT_W'(i) != tgt_reg) && slot_valid_reg[i]
                        && ({1'b0, slot_rank_reg[i]} < old_rank))
                    begin
                        slot_rank_reg[i] <= slot_rank_reg[i] + 1'b1;
                    end
                end
                slot_valid_reg[tgt_reg] <= 1'b1;
                slot_rank_reg[tgt_reg]  <= '0;
            end
        end
    end

    // owner block of each slot
    always_ff @(posedge clk)
    begin
        if (exec_go && inr_reg && (item_reg.mode == MODE_ACCESS))
        begin
            slot_block_reg[tgt_reg] <= item_reg.block_number;
        end
    end

`ifndef SYNTHESIS
    a_accept_to_look: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_LOOK)
        else $error("accepted request did not enter lookup");

    a_evict_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) && evict_reg |-> !free_any)
        else $error("eviction while a free slot exists");

    a_hit_valid_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) && hit_reg |-> slot_valid_reg[tgt_reg])
        else $error("hit on an invalid slot");

    a_rsp_held: assert property (@(posedge clk) disable iff (!rst_n)
        exec_go |=> rsp_valid_reg)
        else $error("response lost");
`endif

endmodule
`default_nettype wire

>>> hdl/lpsm_block_map.sv
`default_nettype none
module lpsm_block_map import lpsm_pkg::*; #(
    parameter int NUM_BLOCKS = NUM_BLOCKS_C
) (
    input  wire logic              clk,
    input  wire map_ctl_t          ctl,
    output logic [SLOT_W-1:0]      rd_data
);

    localparam int MAP_DEPTH = (NUM_BLOCKS < (1 << BLK_W)) ? NUM_BLOCKS : (1 << BLK_W);
    localparam int AW        = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

    // block to slot map, contents undefined until written
    logic [SLOT_W-1:0] mem [MAP_DEPTH];

    // registered read port
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data <= mem[ctl.rd_addr[AW-1:0]];
        end
    end

    // write port
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[ctl.wr_addr[AW-1:0]] <= ctl.wr_data;
        end
    end

endmodule
`default_nettype wire
